/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// clocked property that also holds through reset
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/i2cmbe_pkg.sv */
// shared types, codes and helpers of the i2c master bit engine
package i2cmbe_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned PHASE_W    = 5;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd288;

  // command codes
  localparam logic [2:0] FN_START = 3'd0;
  localparam logic [2:0] FN_STOP  = 3'd1;
  localparam logic [2:0] FN_WRITE = 3'd2;
  localparam logic [2:0] FN_WACK  = 3'd3;
  localparam logic [2:0] FN_READ  = 3'd4;
  localparam logic [2:0] FN_ACK   = 3'd5;
  localparam logic [2:0] FN_NACK  = 3'd6;
  localparam logic [2:0] FN_RSVD  = 3'd7;

  // register index decoded from paddr
  localparam logic REG_PHASE_TICKS = 1'b0;

  // phase numbers that matter inside a read byte or a write byte command
  localparam logic [PHASE_W-1:0] RD_LAST_BIT = PHASE_W'(BYTE_BITS * 2);
  localparam logic [PHASE_W-1:0] RD_ACK_SDA  = PHASE_W'(BYTE_BITS * 2 + 1);
  localparam logic [PHASE_W-1:0] RD_ACK_SCL  = PHASE_W'(BYTE_BITS * 2 + 2);
  localparam logic [PHASE_W-1:0] WR_LAST     = PHASE_W'(BYTE_BITS * 3 - 1);

  typedef struct packed {
    logic                 cmd_valid;
    logic [2:0]           func;
    logic [BYTE_BITS-1:0] tx_byte;
    logic                 read_ack;
    logic                 sda_in;
  } in_item_t;

  typedef struct packed {
    logic                 scl_out;
    logic                 sda_out;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 no_ack;
  } res_item_t;

  // number of bus phases of each command
  function automatic logic [PHASE_W-1:0] phase_count(input logic [2:0] cmd);
    logic [PHASE_W-1:0] n;
    unique case (cmd)
      FN_START: n = PHASE_W'(3);
      FN_STOP:  n = PHASE_W'(2);
      FN_WRITE: n = PHASE_W'(BYTE_BITS * 3);
      FN_WACK:  n = PHASE_W'(3);
      FN_READ:  n = PHASE_W'(BYTE_BITS * 2 + 4);
      default:  n = PHASE_W'(3);
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/i2cmbe_ifs.sv */
// channel interfaces of the i2c master bit engine

interface i2cmbe_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd_valid;
  logic [2:0]                      func;
  logic [i2cmbe_pkg::BYTE_BITS-1:0] tx_byte;
  logic                            read_ack;
  logic                            sda_in;

  modport source (output valid, cmd_valid, func, tx_byte, read_ack, sda_in, input ready);
  modport sink   (input valid, cmd_valid, func, tx_byte, read_ack, sda_in, output ready);
endinterface

interface i2cmbe_out_if;
  logic                            valid;
  logic                            ready;
  logic                            scl_out;
  logic                            sda_out;
  logic                            busy_res;
  logic                            done_res;
  logic [i2cmbe_pkg::BYTE_BITS-1:0] rx_byte;
  logic                            no_ack;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, no_ack,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, no_ack,
                  output ready);
endinterface

/* rtl/core/i2cmbe_cfg.sv */
// apb register block holding the phase length
module i2cmbe_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [i2cmbe_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [i2cmbe_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                 pready,
  output logic [i2cmbe_pkg::TICK_W-1:0]        phase_ticks
);

  logic [i2cmbe_pkg::TICK_W-1:0] phase_ticks_r;
  logic                          wr_en;
  logic                          reg_idx;

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cmbe_pkg::PHASE_TICKS_RST;
    end else if (wr_en && (reg_idx == i2cmbe_pkg::REG_PHASE_TICKS)) begin
      phase_ticks_r <= pwdata[i2cmbe_pkg::TICK_W-1:0];
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    if (reg_idx == i2cmbe_pkg::REG_PHASE_TICKS) begin
      prdata = {{(i2cmbe_pkg::CFG_DATA_W - i2cmbe_pkg::TICK_W){1'b0}}, phase_ticks_r};
    end
  end

  assign phase_ticks = phase_ticks_r;

endmodule

/* rtl/core/i2cmbe_in_stage.sv */
// input register of the tick channel
module i2cmbe_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cmbe_pkg::in_item_t  in_item,
  output logic                  item_valid,
  output i2cmbe_pkg::in_item_t  item,
  input  logic                  item_take
);

  logic                 valid_r;
  logic                 valid_nxt;
  i2cmbe_pkg::in_item_t item_r;
  logic                 accept;

  assign in_ready = !valid_r || item_take;
  assign accept   = in_valid && in_ready;

  // occupancy of the input register
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* rtl/core/i2cmbe_step.sv */
// bus phase sequencer: one tick of state update into the result register
module i2cmbe_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [i2cmbe_pkg::TICK_W-1:0] phase_ticks,
  input  logic                          item_valid,
  input  i2cmbe_pkg::in_item_t          item,
  output logic                          item_take,
  output logic                          res_valid,
  output i2cmbe_pkg::res_item_t         res,
  input  logic                          res_ready
);

  localparam int unsigned PW = i2cmbe_pkg::PHASE_W;
  localparam int unsigned BB = i2cmbe_pkg::BYTE_BITS;

  logic [i2cmbe_pkg::TICK_W-1:0] timer_r, timer_nxt;
  logic [PW-1:0]                 phase_r, phase_nxt;
  logic [1:0]                    sub3_r, sub3_nxt;
  logic [2:0]                    cmd_r, cmd_nxt;
  logic                          run_r, run_nxt;
  logic [BB-1:0]                 shift_r, shift_nxt;
  logic                          rack_r, rack_nxt;
  logic                          scl_r, scl_nxt;
  logic                          sda_r, sda_nxt;
  logic                          ack_r, ack_nxt;
  logic [BB-1:0]                 rx_r, rx_nxt;
  logic                          done_nxt;
  logic                          res_valid_r;
  i2cmbe_pkg::res_item_t         res_r;

  logic                          adv;
  logic                          ep_en;
  logic [PW-1:0]                 ep_p;
  logic [1:0]                    ep_sub;
  logic [PW-1:0]                 phase_inc;
  logic [i2cmbe_pkg::TICK_W-1:0] timer_load;

  assign adv       = item_valid && (!res_valid_r || res_ready);
  assign item_take = adv;
  assign phase_inc = phase_r + PW'(1);
  assign timer_load = (phase_ticks == '0) ? '0 : phase_ticks - 16'd1;

  // next state for one tick
  always_comb begin
    timer_nxt = timer_r;
    phase_nxt = phase_r;
    sub3_nxt  = sub3_r;
    cmd_nxt   = cmd_r;
    run_nxt   = run_r;
    shift_nxt = shift_r;
    rack_nxt  = rack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    done_nxt  = 1'b0;
    ep_en     = 1'b0;
    ep_p      = phase_r;
    ep_sub    = sub3_r;

    // command launch, timer count or phase advance
    if (!run_r) begin
      if (item.cmd_valid && (item.func != i2cmbe_pkg::FN_RSVD)) begin
        cmd_nxt   = item.func;
        run_nxt   = 1'b1;
        phase_nxt = '0;
        sub3_nxt  = 2'd0;
        if (item.func == i2cmbe_pkg::FN_WRITE) begin
          shift_nxt = item.tx_byte;
        end
        if (item.func == i2cmbe_pkg::FN_READ) begin
          rack_nxt = item.read_ack;
        end
        ep_en     = 1'b1;
        ep_p      = '0;
        ep_sub    = 2'd0;
        timer_nxt = timer_load;
      end
    end else if (timer_r != '0) begin
      timer_nxt = timer_r - 16'd1;
    end else if (phase_inc >= i2cmbe_pkg::phase_count(cmd_r)) begin
      run_nxt   = 1'b0;
      done_nxt  = 1'b1;
      phase_nxt = '0;
      if (cmd_r == i2cmbe_pkg::FN_READ) begin
        rx_nxt = shift_r;
        if (rack_r) begin
          sda_nxt = 1'b1;
        end
      end
      if (cmd_r == i2cmbe_pkg::FN_ACK) begin
        sda_nxt = 1'b1;
      end
    end else begin
      phase_nxt = phase_inc;
      sub3_nxt  = (sub3_r == 2'd2) ? 2'd0 : sub3_r + 2'd1;
      ep_en     = 1'b1;
      ep_p      = phase_inc;
      ep_sub    = (sub3_r == 2'd2) ? 2'd0 : sub3_r + 2'd1;
      timer_nxt = timer_load;
    end

    // line levels on entry to a phase
    if (ep_en) begin
      unique case (cmd_nxt)
        i2cmbe_pkg::FN_START: begin
          if (ep_p == PW'(0)) begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end else if (ep_p == PW'(1)) begin
            sda_nxt = 1'b0;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        i2cmbe_pkg::FN_STOP: begin
          if (ep_p == PW'(0)) begin
            sda_nxt = 1'b0;
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b1;
          end
        end
        i2cmbe_pkg::FN_WRITE: begin
          if (ep_sub == 2'd0) begin
            sda_nxt = shift_nxt[BB-1];
          end else if (ep_sub == 2'd1) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
            if (ep_p == i2cmbe_pkg::WR_LAST) begin
              sda_nxt = 1'b1;
            end
            shift_nxt = {shift_nxt[BB-2:0], 1'b0};
          end
        end
        i2cmbe_pkg::FN_WACK: begin
          if (ep_p == PW'(0)) begin
            sda_nxt = 1'b1;
          end else if (ep_p == PW'(1)) begin
            scl_nxt = 1'b1;
          end else begin
            ack_nxt = item.sda_in;
            scl_nxt = 1'b0;
          end
        end
        i2cmbe_pkg::FN_READ: begin
          if (ep_p < i2cmbe_pkg::RD_LAST_BIT) begin
            if (!ep_p[0]) begin
              if (ep_p == PW'(0)) begin
                sda_nxt   = 1'b1;
                shift_nxt = '0;
              end else begin
                shift_nxt = {shift_nxt[BB-2:0], item.sda_in};
              end
              scl_nxt = 1'b0;
            end else begin
              scl_nxt = 1'b1;
            end
          end else if (ep_p == i2cmbe_pkg::RD_LAST_BIT) begin
            shift_nxt = {shift_nxt[BB-2:0], item.sda_in};
            scl_nxt   = 1'b0;
          end else if (ep_p == i2cmbe_pkg::RD_ACK_SDA) begin
            sda_nxt = !rack_nxt;
          end else if (ep_p == i2cmbe_pkg::RD_ACK_SCL) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        default: begin
          // send ack and send nack
          if (ep_p == PW'(0)) begin
            sda_nxt = (cmd_nxt != i2cmbe_pkg::FN_ACK);
          end else if (ep_p == PW'(1)) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
      phase_r <= '0;
      sub3_r  <= 2'd0;
      cmd_r   <= i2cmbe_pkg::FN_START;
      run_r   <= 1'b0;
      shift_r <= '0;
      rack_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      rx_r    <= '0;
    end else if (adv) begin
      timer_r <= timer_nxt;
      phase_r <= phase_nxt;
      sub3_r  <= sub3_nxt;
      cmd_r   <= cmd_nxt;
      run_r   <= run_nxt;
      shift_r <= shift_nxt;
      rack_r  <= rack_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      rx_r    <= rx_nxt;
    end
  end

  // result register occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.scl_out  <= scl_nxt;
      res_r.sda_out  <= sda_nxt;
      res_r.busy_res <= run_nxt;
      res_r.done_res <= done_nxt;
      res_r.rx_byte  <= rx_nxt;
      res_r.no_ack   <= ack_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

/* rtl/core/i2c_master_bit_engine_unit.sv */
// top level of the i2c master bit engine
// Each input transaction is one clock tick of the bus timer: it carries the
// sampled SDA level and, while the engine is idle, an optional command. Every
// tick gives exactly one result transaction with the SCL/SDA drive levels, busy,
// a done pulse, the last received byte and the no-ack flag. One tick is taken
// per clock cycle while the result side does not stall; a tick passes the input
// register and the phase sequencer and only then lands in the result register.
// The input side keeps taking ticks while a finished result waits, until
// both registers are full. Each bus phase lasts phase_ticks ticks (0 counts as
// 1); a start takes 3 phases, a stop 2, a write byte 24, a wait ack 3, a read
// byte with its ack or nack 20, send ack or nack 3, and done pulses on the tick
// after the last phase. phase_ticks sits at byte address 0 of the APB port and
// resets to 288.
module i2c_master_bit_engine_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  i2cmbe_in_if.sink                         in_ch,
  i2cmbe_out_if.source                      out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cmbe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [i2cmbe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [i2cmbe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                              pready
);

  logic [i2cmbe_pkg::TICK_W-1:0] phase_ticks;
  i2cmbe_pkg::in_item_t          in_item;
  i2cmbe_pkg::in_item_t          item;
  logic                          item_valid;
  logic                          item_take;
  i2cmbe_pkg::res_item_t         res;
  logic                          in_ready;
  logic                          res_valid;

  // configuration registers
  i2cmbe_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .phase_ticks (phase_ticks)
  );

  // gather the input payload
  assign in_item.cmd_valid = in_ch.cmd_valid;
  assign in_item.func      = in_ch.func;
  assign in_item.tx_byte   = in_ch.tx_byte;
  assign in_item.read_ack  = in_ch.read_ack;
  assign in_item.sda_in    = in_ch.sda_in;
  assign in_ch.ready       = in_ready;

  i2cmbe_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  i2cmbe_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_ticks (phase_ticks),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (out_ch.ready)
  );

  // drive the result channel
  assign out_ch.valid    = res_valid;
  assign out_ch.scl_out  = res.scl_out;
  assign out_ch.sda_out  = res.sda_out;
  assign out_ch.busy_res = res.busy_res;
  assign out_ch.done_res = res.done_res;
  assign out_ch.rx_byte  = res.rx_byte;
  assign out_ch.no_ack   = res.no_ack;

endmodule

/* rtl/core/i2cmbe_checker.sv */
// port level checks of the i2c master bit engine, bound to the top level
`include "assert_macros.svh"

module i2cmbe_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_scl,
  input logic                             out_sda,
  input logic                             out_busy,
  input logic                             out_done,
  input logic [i2cmbe_pkg::BYTE_BITS-1:0] out_rx,
  input logic                             out_nack,
  input logic                             pready
);

  logic [i2cmbe_pkg::BYTE_BITS+4:0] out_bits;
  logic                             out_stall;

  // result payload as one vector, and a waiting result transaction
  assign out_bits  = {out_scl, out_sda, out_busy, out_done, out_rx, out_nack};
  assign out_stall = out_valid && !out_ready;

  // an empty result register never blocks the input side
  `ASSERT_CLK_RST(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "stall on empty output")

  // a completing command is no longer busy
  `ASSERT_CLK_RST(a_done_not_busy, clk, rst_n, out_valid && out_done |-> !out_busy, "busy on done")

  // a stalled result transaction holds
  `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_bits), "result moved")

  // reset empties the result register
  `ASSERT_CLK(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

  // the apb port never inserts wait states
  `ASSERT_CLK_RST(a_pready_high, clk, rst_n, pready, "pready low")

endmodule

bind i2c_master_bit_engine_unit i2cmbe_checker u_i2cmbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_scl   (out_ch.scl_out),
  .out_sda   (out_ch.sda_out),
  .out_busy  (out_ch.busy_res),
  .out_done  (out_ch.done_res),
  .out_rx    (out_ch.rx_byte),
  .out_nack  (out_ch.no_ack),
  .pready    (pready)
);
